@@ hdl/murh_pkg.sv @@
// Shared constants, operation codes and control types of the move history block.
`default_nettype none

package murh_pkg;

    // Default geometry
    localparam int DEPTH_DEF     = 4096;
    localparam int WORD_BITS_DEF = 32;

    // Fixed field widths on the stream ports
    localparam int MODE_W   = 3;
    localparam int ENTRY_W  = 32;
    localparam int POS_W    = 12;
    localparam int S_DATA_W = 2 * ENTRY_W;
    localparam int M_DATA_W = 48;

    // Operation codes carried in the input tuser
    localparam logic [MODE_W-1:0] MODE_PUSH     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_POP      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REDO     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_UNDO     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TRUNCATE = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd5;

    // Controller to datapath commands
    typedef struct packed {
        logic latch;       // capture the input word
        logic exec;        // update pointers and access the history memory
        logic load_empty;  // load a result with no entry
        logic load_fetch;  // load a result with the entry read from memory
    } murh_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic op_fetch;    // captured operation returns an entry
        logic out_free;    // output register can take a result this cycle
    } murh_sts_t;

endpackage

`default_nettype wire

@@ hdl/murh_ram.sv @@
// Generic single-port RAM with registered read.
`default_nettype none

module murh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
    end

    // Read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[addr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/murh_ctrl.sv @@
// Sequencing controller of the move history: accept, execute, fetch.
`default_nettype none

module murh_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire murh_pkg::murh_sts_t sts,
    output murh_pkg::murh_cmd_t     cmd
);
    import murh_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_FETCH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_axis_tready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.latch      = s_axis_tvalid && (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // reads go ahead at once, the result waits in FETCH
                if (sts.op_fetch)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_FETCH;
                end
                else if (sts.out_free)
                begin
                    cmd.exec       = 1'b1;
                    cmd.load_empty = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_FETCH:
            begin
                if (sts.out_free)
                begin
                    cmd.load_fetch = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/murh_datapath.sv @@
// Pointer registers, slot address, history memory and output register.
`default_nettype none

module murh_datapath #(
    parameter int DEPTH     = murh_pkg::DEPTH_DEF,
    parameter int WORD_BITS = murh_pkg::WORD_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [murh_pkg::MODE_W-1:0]   mode,
    input  wire logic [murh_pkg::ENTRY_W-1:0]  move_word,
    input  wire logic [murh_pkg::ENTRY_W-1:0]  inverse_word,
    input  wire murh_pkg::murh_cmd_t           cmd,
    output murh_pkg::murh_sts_t                sts,
    input  wire logic                          m_ready,
    output logic                               m_valid,
    output logic                               found,
    output logic [murh_pkg::ENTRY_W-1:0]       entry_word,
    output logic [murh_pkg::POS_W-1:0]         position
);
    import murh_pkg::*;

    localparam int              PTR_W   = $clog2(DEPTH);
    localparam logic [PTR_W:0]  DEPTH_X = (PTR_W + 1)'(DEPTH);
    localparam logic [PTR_W-1:0] LAST   = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W-1:0] ONE    = PTR_W'(1);

    // Captured operation
    logic [MODE_W-1:0]  mode_reg;
    logic [ENTRY_W-1:0] move_reg;
    logic [ENTRY_W-1:0] inv_reg;

    // History pointers
    logic [PTR_W-1:0] ring_reg, ring_next;
    logic [PTR_W-1:0] cursor_reg, cursor_next;
    logic [PTR_W-1:0] top_reg, top_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic               found_reg;
    logic [ENTRY_W-1:0] entry_reg;
    logic [POS_W-1:0]   pos_reg;

    logic is_push, is_pop, is_redo, is_undo, is_trunc, is_clear;
    logic can_back, can_fwd, step_back;
    logic [PTR_W-1:0] offset, ring_inc, cursor_inc, addr;
    logic [PTR_W:0]   slot_sum;
    logic [2*WORD_BITS-1:0] wr_data, rd_data;
    logic [WORD_BITS-1:0]   move_st, inv_st;
    logic [ENTRY_W-1:0]     rd_move, rd_inv;
    logic [POS_W-1:0]       pos_now, pos_cur;

    // Operation decode
    assign is_push  = (mode_reg == MODE_PUSH);
    assign is_pop   = (mode_reg == MODE_POP);
    assign is_redo  = (mode_reg == MODE_REDO);
    assign is_undo  = (mode_reg == MODE_UNDO);
    assign is_trunc = (mode_reg == MODE_TRUNCATE);
    assign is_clear = (mode_reg == MODE_CLEAR);

    assign can_back  = (cursor_reg != '0);
    assign can_fwd   = (cursor_reg < top_reg);
    assign step_back = is_pop || is_undo;

    assign sts.op_fetch = (step_back && can_back) || (is_redo && can_fwd);
    assign sts.out_free = !out_valid_reg || m_ready;

    // Slot address: ring start plus offset, wrapped once
    assign offset   = step_back ? cursor_reg - ONE : cursor_reg;
    assign slot_sum = {1'b0, ring_reg} + {1'b0, offset};
    assign addr     = (slot_sum >= DEPTH_X) ? PTR_W'(slot_sum - DEPTH_X)
                                            : slot_sum[PTR_W-1:0];

    assign ring_inc   = (ring_reg == LAST) ? '0 : ring_reg + ONE;
    assign cursor_inc = cursor_reg + ONE;

    // Pointer update; unused modes leave everything as is
    always_comb
    begin
        ring_next   = ring_reg;
        cursor_next = cursor_reg;
        top_next    = top_reg;
        if (cmd.exec)
        begin
            if (is_push)
            begin
                if (cursor_reg != LAST)
                begin
                    cursor_next = cursor_inc;
                    if (cursor_inc > top_reg)
                    begin
                        top_next = cursor_inc;
                    end
                end
                else
                begin
                    // full history: oldest move drops out
                    ring_next = ring_inc;
                end
            end
            else if (step_back)
            begin
                if (can_back)
                begin
                    cursor_next = cursor_reg - ONE;
                end
            end
            else if (is_redo)
            begin
                if (can_fwd)
                begin
                    cursor_next = cursor_inc;
                end
            end
            else if (is_trunc)
            begin
                top_next = cursor_reg;
            end
            else if (is_clear)
            begin
                cursor_next = '0;
                top_next    = '0;
            end
        end
    end

    // Word width adaptation between ports and memory
    generate
        if (WORD_BITS <= ENTRY_W)
        begin : g_wr_narrow
            assign move_st = move_reg[WORD_BITS-1:0];
            assign inv_st  = inv_reg[WORD_BITS-1:0];
        end
        else
        begin : g_wr_wide
            assign move_st = {{(WORD_BITS-ENTRY_W){1'b0}}, move_reg};
            assign inv_st  = {{(WORD_BITS-ENTRY_W){1'b0}}, inv_reg};
        end
        if (WORD_BITS >= ENTRY_W)
        begin : g_rd_wide
            assign rd_move = rd_data[ENTRY_W-1:0];
            assign rd_inv  = rd_data[WORD_BITS+ENTRY_W-1:WORD_BITS];
        end
        else
        begin : g_rd_narrow
            assign rd_move = {{(ENTRY_W-WORD_BITS){1'b0}}, rd_data[WORD_BITS-1:0]};
            assign rd_inv  = {{(ENTRY_W-WORD_BITS){1'b0}},
                              rd_data[2*WORD_BITS-1:WORD_BITS]};
        end
        if (PTR_W >= POS_W)
        begin : g_pos_trunc
            assign pos_now = cursor_next[POS_W-1:0];
            assign pos_cur = cursor_reg[POS_W-1:0];
        end
        else
        begin : g_pos_ext
            assign pos_now = {{(POS_W-PTR_W){1'b0}}, cursor_next};
            assign pos_cur = {{(POS_W-PTR_W){1'b0}}, cursor_reg};
        end
    endgenerate

    assign wr_data = {inv_st, move_st};

    // Move and inverse stored side by side
    murh_ram #(
        .WIDTH (2 * WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.exec && is_push),
        .rd_en   (cmd.exec && sts.op_fetch),
        .addr    (addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    // Input capture
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            mode_reg <= mode;
            move_reg <= move_word;
            inv_reg  <= inverse_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_reg   <= '0;
            cursor_reg <= '0;
            top_reg    <= '0;
        end
        else
        begin
            ring_reg   <= ring_next;
            cursor_reg <= cursor_next;
            top_reg    <= top_next;
        end
    end

    // Output word valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_empty || cmd.load_fetch)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_empty)
        begin
            found_reg <= 1'b0;
            entry_reg <= '0;
            pos_reg   <= pos_now;
        end
        else if (cmd.load_fetch)
        begin
            found_reg <= 1'b1;
            entry_reg <= is_undo ? rd_inv : rd_move;
            pos_reg   <= pos_cur;
        end
    end

    assign m_valid    = out_valid_reg;
    assign found      = found_reg;
    assign entry_word = entry_reg;
    assign position   = pos_reg;

endmodule

`default_nettype wire

@@ hdl/move_undo_redo_history.sv @@
// Top level of the undo/redo move history.
//
// Input stream (s_axis): one word per operation. tuser carries the mode
// (push, pop, redo, undo, truncate, clear); tdata carries the move word and
// its inverse, used by push only.
// Output stream (m_axis): exactly one word per operation. tuser is the found
// flag; tdata holds the returned move or inverse (zero when nothing found)
// and the cursor position after the operation.
// Timing: one operation at a time. tready drops after each accept and
// rises once the operation has executed, after the fetch as well for a pop,
// redo or undo that finds an entry, and stays low while a result waits. A
// result that needs no memory read is loaded in the execute state, a
// returning pop, redo or undo in the fetch state after the registered read
// of the history memory. A new word is taken once the last result is loaded.
// Stall: a waiting result sits in the output register; the next word is still
// accepted. A returning read goes ahead and its result waits; any other
// operation holds in execute until the output frees.
// Reset: cursor, top mark and ring start clear to zero; the memory content is
// not cleared and no clearing pass is needed.
`default_nettype none

module move_undo_redo_history #(
    parameter int DEPTH     = murh_pkg::DEPTH_DEF,
    parameter int WORD_BITS = murh_pkg::WORD_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [murh_pkg::S_DATA_W-1:0]  s_axis_tdata,  // move_word, inverse_word
    input  wire logic [murh_pkg::MODE_W-1:0]    s_axis_tuser,  // mode
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [murh_pkg::M_DATA_W-1:0]       m_axis_tdata,  // entry_word, position, pad
    output logic                                m_axis_tuser   // found
);
    import murh_pkg::*;

    murh_cmd_t          cmd;
    murh_sts_t          sts;
    logic               found;
    logic [ENTRY_W-1:0] entry_word;
    logic [POS_W-1:0]   position;

    murh_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    murh_datapath #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .mode         (s_axis_tuser),
        .move_word    (s_axis_tdata[ENTRY_W-1:0]),
        .inverse_word (s_axis_tdata[2*ENTRY_W-1:ENTRY_W]),
        .cmd          (cmd),
        .sts          (sts),
        .m_ready      (m_axis_tready),
        .m_valid      (m_axis_tvalid),
        .found        (found),
        .entry_word   (entry_word),
        .position     (position)
    );

    // Pack result word
    assign m_axis_tdata = {{(M_DATA_W-ENTRY_W-POS_W){1'b0}}, position, entry_word};
    assign m_axis_tuser = found;

endmodule

`default_nettype wire

@@ hdl/murh_checker.sv @@
// Port-level assertions for the move history, bound to the top level.
`default_nettype none

module murh_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [murh_pkg::M_DATA_W-1:0]  m_axis_tdata,
    input wire logic                           m_axis_tuser
);
    import murh_pkg::*;

    logic s_acc;

    assign s_acc = s_axis_tvalid && s_axis_tready;

    // Stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                           && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // Only one operation in flight
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc |=> !s_axis_tready)
        else $error("input accepted back to back");

    // A result never appears the cycle right after accept
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc |=> !$rose(m_axis_tvalid))
        else $error("result appeared too early");

    // No entry found means a zero entry and zero padding
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[ENTRY_W-1:0] == '0
                                           && m_axis_tdata[M_DATA_W-1:ENTRY_W+POS_W] == '0)
        else $error("empty result carries data");

endmodule

bind move_undo_redo_history murh_checker u_murh_checker (.*);

`default_nettype wire
